// ----- hdl/api_tx_pkg.sv -----
// Package for the API transmit-request framer: queue entry, config and status types,
// frame byte positions and protocol constants. No dependencies.
package api_tx_pkg;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Protocol constants
    localparam logic [7:0]  START_DELIM = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE  = 8'h10;
    localparam logic [7:0]  CSUM_BASE   = 8'hFF;
    localparam logic [15:0] LEN_OFFSET  = 16'd14;
    localparam logic [7:0]  FRAME_ID_RST  = 8'h01;
    localparam logic [15:0] NET_ADDR_RST  = 16'hFFFE;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS  = 2'd3;
    localparam int CFG_DATA_W = 16;

    // Position of an output byte within the frame
    typedef logic [4:0] t_pos;
    localparam t_pos POS_START   = 5'd0;
    localparam t_pos POS_LEN_HI  = 5'd1;
    localparam t_pos POS_LEN_LO  = 5'd2;
    localparam t_pos POS_TYPE    = 5'd3;
    localparam t_pos POS_FRAME_ID = 5'd4;
    localparam t_pos POS_ADDR0   = 5'd5;
    localparam t_pos POS_ADDR7   = 5'd12;
    localparam t_pos POS_NET_HI  = 5'd13;
    localparam t_pos POS_NET_LO  = 5'd14;
    localparam t_pos POS_RADIUS  = 5'd15;
    localparam t_pos POS_OPTIONS = 5'd16;
    localparam t_pos POS_DATA    = 5'd17;
    localparam t_pos POS_CHECK   = 5'd18;

    // One classified item as it waits in the queue
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        first_byte;
        logic        last_byte;
        logic [63:0] dest_address;
        logic [7:0]  payload_length;
    } t_entry;

    // Queue status seen by front and back
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_qstat;

    // Header fields held in configuration registers
    typedef struct packed {
        logic [7:0]  frame_id;
        logic [15:0] dest_network_address;
        logic [7:0]  broadcast_radius;
        logic [7:0]  transmit_options;
    } t_cfg;

endpackage

// ----- hdl/api_tx_in_if.sv -----
// Input channel of the framer: valid/ready handshake with one payload byte and frame info.
// Depends on nothing.
interface api_tx_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic [63:0] dest_address;
    logic [7:0]  payload_length;

    modport source (
        output valid, payload_byte, first_byte, last_byte, dest_address, payload_length,
        input  ready
    );
    modport sink (
        input  valid, payload_byte, first_byte, last_byte, dest_address, payload_length,
        output ready
    );
endinterface

// ----- hdl/api_tx_out_if.sv -----
// Output channel of the framer: valid/ready handshake with one framed byte and flags.
// Depends on nothing.
interface api_tx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;
    logic       length_mismatch;

    modport source (
        output valid, out_byte, end_of_run, end_of_frame, length_mismatch,
        input  ready
    );
    modport sink (
        input  valid, out_byte, end_of_run, end_of_frame, length_mismatch,
        output ready
    );
endinterface

// ----- hdl/api_tx_queue.sv -----
// Short FIFO of classified items between the front and the back of the framer.
// Depends on api_tx_pkg.
module api_tx_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  api_tx_pkg::t_entry i_entry,
    input  logic               i_pop,
    output api_tx_pkg::t_entry o_head,
    output api_tx_pkg::t_qstat o_stat
);

    api_tx_pkg::t_entry r_mem [api_tx_pkg::QUEUE_DEPTH];
    logic [api_tx_pkg::QPTR_W-1:0] r_wr;
    logic [api_tx_pkg::QPTR_W-1:0] r_rd;
    logic [api_tx_pkg::QPTR_W:0]   r_cnt;

    // Storage is written at the tail only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head           = r_mem[r_rd];
    assign o_stat.not_empty = (r_cnt != '0);
    assign o_stat.full      = (r_cnt == (api_tx_pkg::QPTR_W+1)'(api_tx_pkg::QUEUE_DEPTH));

endmodule

// ----- hdl/api_tx_front.sv -----
// Front end of the framer: accepts input items, tracks whether a frame is open,
// drops stray bytes and queues the rest. Depends on api_tx_pkg and api_tx_in_if.
module api_tx_front #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    api_tx_in_if.sink          i_req,
    input  api_tx_pkg::t_qstat i_qstat,
    output logic               o_push,
    output api_tx_pkg::t_entry o_entry
);

    // The length field is eight bits, so the limit only bites below 255.
    localparam int         SAT_LEN  = (MAX_PAYLOAD < 255) ? MAX_PAYLOAD : 255;
    localparam logic [7:0] SAT_LEN8 = 8'(SAT_LEN);

    logic r_frame_open;
    logic w_accept;
    logic w_keep;

    // Accept whenever the queue has room.
    assign i_req.ready = !i_qstat.full;
    assign w_accept    = i_req.valid && i_req.ready;

    // A byte is kept if it opens a frame or belongs to an open one.
    assign w_keep = i_req.first_byte || r_frame_open;
    assign o_push = w_accept && w_keep;

    // Build the queue entry, with the declared length saturated.
    always_comb begin
        o_entry.payload_byte   = i_req.payload_byte;
        o_entry.first_byte     = i_req.first_byte;
        o_entry.last_byte      = i_req.last_byte;
        o_entry.dest_address   = i_req.dest_address;
        o_entry.payload_length = (i_req.payload_length > SAT_LEN8) ? SAT_LEN8
                                                                   : i_req.payload_length;
    end

    // Frame open tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
        end else if (o_push) begin
            r_frame_open <= !i_req.last_byte;
        end
    end

endmodule

// ----- hdl/api_tx_back.sv -----
// Back end of the framer: walks each queued item through its header (if first), data and checksum (if last)
// positions, one byte per cycle into the output register unless stalled. Depends on api_tx_pkg, api_tx_out_if.
module api_tx_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [api_tx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [api_tx_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  api_tx_pkg::t_entry                  i_head,
    input  api_tx_pkg::t_qstat                  i_qstat,
    output logic                                o_pop,
    api_tx_out_if.source                        o_frm
);

    api_tx_pkg::t_cfg r_cfg;
    api_tx_pkg::t_pos r_pos;
    logic             r_busy;
    logic [7:0]       r_sum;
    logic [7:0]       r_seen;
    logic [7:0]       r_declared;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_eor;
    logic             r_eof;
    logic             r_mism;

    api_tx_pkg::t_pos w_pos;
    api_tx_pkg::t_pos w_end;
    logic             w_adv;
    logic             w_go;
    logic [15:0]      w_total;
    logic [2:0]       w_addr_idx;
    logic [63:0]      w_addr_shift;
    logic [7:0]       w_byte;
    logic             w_summed;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_id             <= api_tx_pkg::FRAME_ID_RST;
            r_cfg.dest_network_address <= api_tx_pkg::NET_ADDR_RST;
            r_cfg.broadcast_radius     <= 8'd0;
            r_cfg.transmit_options     <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                api_tx_pkg::CFG_FRAME_ID: r_cfg.frame_id <= i_cfg_data[7:0];
                api_tx_pkg::CFG_NET_ADDR: r_cfg.dest_network_address <= i_cfg_data;
                api_tx_pkg::CFG_RADIUS:   r_cfg.broadcast_radius <= i_cfg_data[7:0];
                api_tx_pkg::CFG_OPTIONS:  r_cfg.transmit_options <= i_cfg_data[7:0];
                default:                  r_cfg <= r_cfg;
            endcase
        end
    end

    // Current position: a fresh item starts at the header or straight at its data byte.
    assign w_pos = r_busy ? r_pos
                          : (i_head.first_byte ? api_tx_pkg::POS_START : api_tx_pkg::POS_DATA);
    assign w_end = i_head.last_byte ? api_tx_pkg::POS_CHECK : api_tx_pkg::POS_DATA;

    // The output register moves when empty or when its byte is taken.
    assign w_adv = !r_valid || o_frm.ready;
    assign w_go  = w_adv && i_qstat.not_empty;
    assign o_pop = w_go && (w_pos == w_end);

    // Byte selection for the current position.
    assign w_total      = api_tx_pkg::LEN_OFFSET + {8'd0, i_head.payload_length};
    assign w_addr_idx   = 3'(w_pos - api_tx_pkg::POS_ADDR0);
    assign w_addr_shift = i_head.dest_address << {w_addr_idx, 3'b000};
    assign w_summed     = (w_pos >= api_tx_pkg::POS_TYPE) && (w_pos <= api_tx_pkg::POS_DATA);

    always_comb begin
        case (w_pos)
            api_tx_pkg::POS_START:    w_byte = api_tx_pkg::START_DELIM;
            api_tx_pkg::POS_LEN_HI:   w_byte = w_total[15:8];
            api_tx_pkg::POS_LEN_LO:   w_byte = w_total[7:0];
            api_tx_pkg::POS_TYPE:     w_byte = api_tx_pkg::FRAME_TYPE;
            api_tx_pkg::POS_FRAME_ID: w_byte = r_cfg.frame_id;
            api_tx_pkg::POS_NET_HI:   w_byte = r_cfg.dest_network_address[15:8];
            api_tx_pkg::POS_NET_LO:   w_byte = r_cfg.dest_network_address[7:0];
            api_tx_pkg::POS_RADIUS:   w_byte = r_cfg.broadcast_radius;
            api_tx_pkg::POS_OPTIONS:  w_byte = r_cfg.transmit_options;
            api_tx_pkg::POS_DATA:     w_byte = i_head.payload_byte;
            api_tx_pkg::POS_CHECK:    w_byte = api_tx_pkg::CSUM_BASE - r_sum;
            default:                  w_byte = w_addr_shift[63:56];
        endcase
    end

    // Position sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= api_tx_pkg::POS_START;
        end else if (w_go) begin
            r_busy <= (w_pos != w_end);
            r_pos  <= w_pos + 1'b1;
        end
    end

    // Checksum sum and byte count of the open frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= 8'd0;
            r_seen     <= 8'd0;
            r_declared <= 8'd0;
        end else if (w_go) begin
            if (w_pos == api_tx_pkg::POS_START) begin
                r_sum      <= 8'd0;
                r_seen     <= 8'd0;
                r_declared <= i_head.payload_length;
            end else if (w_pos == api_tx_pkg::POS_CHECK) begin
                r_sum      <= 8'd0;
                r_seen     <= 8'd0;
                r_declared <= 8'd0;
            end else begin
                if (w_summed) begin
                    r_sum <= r_sum + w_byte;
                end
                if ((w_pos == api_tx_pkg::POS_DATA) && (r_seen != 8'hFF)) begin
                    r_seen <= r_seen + 8'd1;
                end
            end
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= w_go;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_byte <= w_byte;
            r_eor  <= (w_pos == w_end);
            r_eof  <= (w_pos == api_tx_pkg::POS_CHECK);
            r_mism <= (w_pos == api_tx_pkg::POS_CHECK) && (r_seen != r_declared);
        end
    end

    assign o_frm.valid           = r_valid;
    assign o_frm.out_byte        = r_byte;
    assign o_frm.end_of_run      = r_eor;
    assign o_frm.end_of_frame    = r_eof;
    assign o_frm.length_mismatch = r_mism;

endmodule

// ----- hdl/api_tx_request_framer.sv -----
// API transmit-request framer.
// Input channel i_req carries payload bytes with first/last marks; the byte marked first also
// carries the 64-bit destination address and the declared payload length. Output channel o_frm
// carries the framed byte stream: on the first byte a 17-byte header (delimiter, length, frame
// type, frame id, address, network address, radius, options), then each payload byte, and
// after the last byte a checksum flagged end_of_frame, with length_mismatch set when the count
// of bytes differs from the declared length. end_of_run marks the last byte caused by an item.
// Four header registers are written through the i_cfg_* port. The user must write them only
// while the block is idle; the block itself does not enforce this. An accepted item enters a
// four-entry queue, and the back end moves its bytes from there into the output register.
// The output side produces one byte per cycle while o_frm is not stalled; a plain payload item
// yields one byte, an opening item 18 bytes and a closing item one more, its checksum;
// the output sequencer sets the sustained rate. The input accepts one item per cycle while the
// queue has room; bytes with no open frame are dropped at the input and produce nothing.
// A stall on o_frm holds the output register, then fills the queue, then lowers i_req.ready.
// Synchronous reset empties the queue, closes any frame and restores the register defaults.
// Depends on api_tx_pkg, api_tx_in_if, api_tx_out_if, api_tx_front, api_tx_queue, api_tx_back.
module api_tx_request_framer #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [api_tx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [api_tx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    api_tx_in_if.sink                         i_req,
    api_tx_out_if.source                      o_frm
);

    api_tx_pkg::t_entry w_entry;
    api_tx_pkg::t_entry w_head;
    api_tx_pkg::t_qstat w_qstat;
    logic               w_push;
    logic               w_pop;

    // Input classification.
    api_tx_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    // Decoupling queue.
    api_tx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    // Frame byte generation.
    api_tx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_frm       (o_frm)
    );

    // A mismatch flag only ever rides on the checksum byte.
    a_mism_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frm.valid && o_frm.length_mismatch |-> o_frm.end_of_frame)
        else $error("length_mismatch outside checksum byte");

    // The checksum always ends the run of its item.
    a_check_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frm.valid && o_frm.end_of_frame |-> o_frm.end_of_run)
        else $error("checksum byte without end_of_run");

    // A queued item is visible to the back end in the next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> w_qstat.not_empty)
        else $error("queued item lost");

    // The queue is never popped while empty.
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qstat.not_empty)
        else $error("pop from empty queue");

endmodule

// ----- tb/sv/tb_api_tx_request_framer.sv -----
// Self-checking testbench for api_tx_request_framer: directed and random payload streams,
// header register writes, random idling on both channels, and a scoreboard of framed bytes.
// Depends on api_tx_pkg, api_tx_in_if, api_tx_out_if and the framer RTL.
`timescale 1ns / 100ps

module tb_api_tx_request_framer;

    localparam int PAYLOAD_LIMIT  = 255;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 20;

    // One expected byte of the framed output stream
    typedef struct {
        logic [7:0] out_byte;
        bit         end_of_run;
        bit         end_of_frame;
        bit         length_mismatch;
    } t_frm_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [api_tx_pkg::CFG_IDX_W-1:0] i_cfg_index = api_tx_pkg::CFG_FRAME_ID;
    logic [api_tx_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic frm_ready = 1'b1;

    api_tx_in_if  req_if ();
    api_tx_out_if frm_if ();

    assign frm_if.ready = frm_ready;

    api_tx_request_framer #(
        .MAX_PAYLOAD (PAYLOAD_LIMIT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .o_frm       (frm_if)
    );

    // Header register copies held by the predictor
    logic [7:0]  hdr_frame_id = api_tx_pkg::FRAME_ID_RST;
    logic [15:0] hdr_net_addr = api_tx_pkg::NET_ADDR_RST;
    logic [7:0]  hdr_radius   = 8'h00;
    logic [7:0]  hdr_options  = 8'h00;

    // Frame state of the predictor
    logic [7:0] csum_acc = 8'h00;
    logic [7:0] count_seen = 8'h00;
    logic [7:0] count_declared = 8'h00;
    bit         in_frame = 1'b0;

    t_frm_byte expected_bytes[$];
    int        fail_count = 0;
    int        bytes_checked = 0;
    int        items_framed = 0;
    int        stall_cycles = 0;
    bit        send_idle_en = 1'b1;
    bit        sink_stall_en = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Appends one byte to the expected stream; bytes flagged summed (header after the length, data) are summed.
    function automatic void emit_byte(input logic [7:0] b, input bit summed, input bit eof,
                                      input bit mism);
        t_frm_byte e;
        e.out_byte        = b;
        e.end_of_run      = 1'b0;
        e.end_of_frame    = eof;
        e.length_mismatch = mism;
        expected_bytes.push_back(e);
        if (summed) csum_acc = csum_acc + b;
    endfunction

    // Works out the framed bytes that one accepted item causes.
    function automatic void predict_frame(input logic [7:0] data, input bit first,
                                          input bit last, input logic [63:0] addr,
                                          input logic [7:0] plen);
        logic [15:0] total;
        logic [7:0]  decl;
        decl = plen;
        if (first) begin
            if (int'(decl) > PAYLOAD_LIMIT) decl = 8'(PAYLOAD_LIMIT);
            count_declared = decl;
            count_seen     = 8'h00;
            csum_acc       = 8'h00;
            in_frame       = 1'b1;
            total          = api_tx_pkg::LEN_OFFSET + 16'(decl);
            emit_byte(api_tx_pkg::START_DELIM, 1'b0, 1'b0, 1'b0);
            emit_byte(total[15:8], 1'b0, 1'b0, 1'b0);
            emit_byte(total[7:0], 1'b0, 1'b0, 1'b0);
            emit_byte(api_tx_pkg::FRAME_TYPE, 1'b1, 1'b0, 1'b0);
            emit_byte(hdr_frame_id, 1'b1, 1'b0, 1'b0);
            for (int k = 7; k >= 0; k--) emit_byte(addr[8*k +: 8], 1'b1, 1'b0, 1'b0);
            emit_byte(hdr_net_addr[15:8], 1'b1, 1'b0, 1'b0);
            emit_byte(hdr_net_addr[7:0], 1'b1, 1'b0, 1'b0);
            emit_byte(hdr_radius, 1'b1, 1'b0, 1'b0);
            emit_byte(hdr_options, 1'b1, 1'b0, 1'b0);
        end
        // A byte with no frame open is dropped.
        if (!in_frame) return;
        emit_byte(data, 1'b1, 1'b0, 1'b0);
        if (count_seen != 8'hFF) count_seen = count_seen + 8'd1;
        if (last) begin
            emit_byte(api_tx_pkg::CSUM_BASE - csum_acc, 1'b0, 1'b1,
                      count_seen != count_declared);
            in_frame       = 1'b0;
            csum_acc       = 8'h00;
            count_seen     = 8'h00;
            count_declared = 8'h00;
        end
        expected_bytes[expected_bytes.size() - 1].end_of_run = 1'b1;
    endfunction

    // Sends one item, with an optional random gap first; returns at the accepting edge.
    task automatic send_req(input logic [7:0] data, input bit first, input bit last,
                            input logic [63:0] addr, input logic [7:0] plen);
        int before_cnt;
        if (send_idle_en && $urandom_range(0, 99) < 20) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.payload_byte   <= data;
        req_if.first_byte     <= first;
        req_if.last_byte      <= last;
        req_if.dest_address   <= addr;
        req_if.payload_length <= plen;
        @(negedge i_clk);
        while (!req_if.ready) @(negedge i_clk);
        before_cnt = expected_bytes.size();
        predict_frame(data, first, last, addr, plen);
        if (expected_bytes.size() != before_cnt) items_framed++;
        @(posedge i_clk);
    endtask

    // Holds the sender until every expected byte has arrived, then lets the block settle.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four header registers while the block is idle.
    task automatic set_header(input logic [7:0] fid, input logic [15:0] net,
                              input logic [7:0] rad, input logic [7:0] opt);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= api_tx_pkg::CFG_FRAME_ID;
        i_cfg_data  <= {8'($urandom_range(0, 255)), fid};
        @(posedge i_clk);
        i_cfg_index <= api_tx_pkg::CFG_NET_ADDR;
        i_cfg_data  <= net;
        @(posedge i_clk);
        i_cfg_index <= api_tx_pkg::CFG_RADIUS;
        i_cfg_data  <= {8'($urandom_range(0, 255)), rad};
        @(posedge i_clk);
        i_cfg_index <= api_tx_pkg::CFG_OPTIONS;
        i_cfg_data  <= {8'($urandom_range(0, 255)), opt};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        hdr_frame_id = fid;
        hdr_net_addr = net;
        hdr_radius   = rad;
        hdr_options  = opt;
    endtask

    // Sends one random frame: mostly well formed, the rest broken or stray.
    task automatic send_random_frame();
        int kind;
        int len;
        int n_bytes;
        bit closes;
        logic [7:0] decl;
        logic [63:0] addr;
        kind    = $urandom_range(0, 99);
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        decl    = 8'(len);
        n_bytes = len;
        closes  = 1'b1;
        addr    = {$urandom, $urandom};
        if (kind >= 95) begin
            // Stray bytes; dropped unless an abandoned frame is still open.
            repeat ($urandom_range(1, 3))
                send_req(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), {$urandom, $urandom},
                         8'($urandom));
            return;
        end else if (kind >= 90) begin
            n_bytes = $urandom_range(1, len);
            closes  = 1'b0;
        end else if (kind >= 85) begin
            decl    = 8'h00;
            n_bytes = $urandom_range(1, 3);
        end else if (kind >= 75) begin
            n_bytes = $urandom_range(1, len + 3);
            if ($urandom_range(0, 3) == 0) decl = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < n_bytes; i++)
            send_req(8'($urandom), i == 0, closes && (i == n_bytes - 1),
                     (i == 0) ? addr : {$urandom, $urandom},
                     (i == 0) ? decl : 8'($urandom));
    endtask

    // Frames with the register values left by reset.
    task automatic test_default_header();
        send_req(8'h00, 1'b1, 1'b0, 64'h0000_0000_0000_0000, 8'd2);
        send_req(8'hFF, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_req(8'hFF, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd3);
        send_req(8'h5A, 1'b0, 1'b0, 64'h0, 8'h00);
        send_req(8'hA5, 1'b0, 1'b1, 64'h0, 8'h00);
    endtask

    // Special cases of the framing rules.
    task automatic test_directed_frames();
        // Bytes with no frame open are dropped, with or without the last mark.
        send_req(8'h33, 1'b0, 1'b0, 64'h0123_4567_89AB_CDEF, 8'd4);
        send_req(8'hCC, 1'b0, 1'b1, 64'hFEDC_BA98_7654_3210, 8'd4);
        // First and last on one item: header, byte and checksum together.
        send_req(8'h00, 1'b1, 1'b1, 64'h0, 8'd1);
        // A declared length of zero: any byte counts as a mismatch.
        send_req(8'h81, 1'b1, 1'b1, 64'h8000_0000_0000_0001, 8'd0);
        // A new frame abandons the open one without a checksum.
        send_req(8'h11, 1'b1, 1'b0, 64'h1111_2222_3333_4444, 8'd4);
        send_req(8'h22, 1'b0, 1'b0, 64'h0, 8'h00);
        send_req(8'h44, 1'b1, 1'b0, 64'h5555_6666_7777_8888, 8'd2);
        send_req(8'h55, 1'b0, 1'b1, 64'h0, 8'h00);
        // Fewer bytes than declared.
        send_req(8'h66, 1'b1, 1'b0, 64'hAAAA_5555_AAAA_5555, 8'd5);
        send_req(8'h77, 1'b0, 1'b1, 64'h0, 8'h00);
        // More bytes than declared.
        send_req(8'h88, 1'b1, 1'b0, 64'h5555_AAAA_5555_AAAA, 8'd1);
        send_req(8'h99, 1'b0, 1'b0, 64'h0, 8'h00);
        send_req(8'hAA, 1'b0, 1'b1, 64'h0, 8'h00);
    endtask

    // Header registers at both extremes.
    task automatic test_header_registers();
        set_header(8'h00, 16'h0000, 8'h00, 8'h00);
        send_req(8'h12, 1'b1, 1'b0, 64'hDEAD_BEEF_0000_FFFF, 8'd2);
        send_req(8'h34, 1'b0, 1'b1, 64'h0, 8'h00);
        set_header(8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_req(8'hFE, 1'b1, 1'b0, 64'h0F0F_F0F0_0F0F_F0F0, 8'd2);
        send_req(8'h01, 1'b0, 1'b1, 64'h0, 8'h00);
    endtask

    // A full-length frame with two surplus bytes: the saturated count hides the surplus.
    // Both sides run without idling here, which gives one long unbroken stretch.
    task automatic test_count_saturation();
        set_header(8'h5C, 16'h1234, 8'h07, 8'h20);
        send_idle_en  = 1'b0;
        sink_stall_en = 1'b0;
        send_req(8'($urandom), 1'b1, 1'b0, {$urandom, $urandom}, 8'd255);
        for (int i = 1; i < 257; i++)
            send_req(8'($urandom), 1'b0, i == 256, {$urandom, $urandom}, 8'($urandom));
        send_idle_en  = 1'b1;
        sink_stall_en = 1'b1;
    endtask

    // Random traffic over several register settings, one phase without idling and one
    // with the sender held until the output has drained.
    task automatic test_random_traffic();
        int phase_start;
        bit paused;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 3)
                set_header(8'hFF, 16'hFFFF, 8'h00, 8'hFF);
            else
                set_header(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            send_idle_en  = (phase != 2);
            sink_stall_en = (phase != 2);
            phase_start   = items_framed;
            paused        = 1'b0;
            while (items_framed - phase_start < PHASE_ITEMS) begin
                if (phase == 1 && !paused && items_framed - phase_start >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_random_frame();
            end
        end
        send_idle_en  = 1'b1;
        sink_stall_en = 1'b1;
    endtask

    // Output ready with random stalls.
    always @(posedge i_clk) begin
        frm_ready <= !sink_stall_en || ($urandom_range(0, 99) >= 20);
    end

    // Compares each accepted output byte with the oldest expectation.
    always @(negedge i_clk) begin : frame_checker
        t_frm_byte want;
        if (i_rst_n && frm_if.valid && frm_if.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h eor=%b eof=%b mism=%b",
                                          frm_if.out_byte, frm_if.end_of_run,
                                          frm_if.end_of_frame, frm_if.length_mismatch));
            end else begin
                want = expected_bytes.pop_front();
                if (frm_if.out_byte !== want.out_byte || frm_if.end_of_run !== want.end_of_run
                        || frm_if.end_of_frame !== want.end_of_frame
                        || frm_if.length_mismatch !== want.length_mismatch)
                    report_mismatch($sformatf(
                        "byte %0d: got %02h/%b/%b/%b, expected %02h/%b/%b/%b",
                        bytes_checked, frm_if.out_byte, frm_if.end_of_run,
                        frm_if.end_of_frame, frm_if.length_mismatch, want.out_byte,
                        want.end_of_run, want.end_of_frame, want.length_mismatch));
            end
            bytes_checked++;
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (frm_if.valid && frm_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d bytes outstanding", expected_bytes.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        req_if.valid          <= 1'b0;
        req_if.payload_byte   <= 8'h00;
        req_if.first_byte     <= 1'b0;
        req_if.last_byte      <= 1'b0;
        req_if.dest_address   <= 64'h0;
        req_if.payload_length <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_header();
        test_directed_frames();
        test_header_registers();
        test_count_saturation();
        test_random_traffic();
        wait_drained();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- api_tx_request_framer.f -----
hdl/api_tx_pkg.sv
hdl/api_tx_in_if.sv
hdl/api_tx_out_if.sv
hdl/api_tx_queue.sv
hdl/api_tx_front.sv
hdl/api_tx_back.sv
hdl/api_tx_request_framer.sv
tb/sv/tb_api_tx_request_framer.sv
